// File: rtl/symmetric_flow_hash_dispatch_defines.svh
// Assertion macros shared by the flow hash dispatch RTL.
// Needs a clock named clk and a reset named rst in the using module.
`ifndef SYMMETRIC_FLOW_HASH_DISPATCH_DEFINES_SVH
`define SYMMETRIC_FLOW_HASH_DISPATCH_DEFINES_SVH

// Property must hold at every edge outside reset.
`define SFH_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("sfh assertion failed");

// Antecedent implies consequent in the same cycle.
`define SFH_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfh assertion failed");

// Antecedent implies consequent in the next cycle.
`define SFH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfh assertion failed");

`endif

// File: rtl/sfh_pkg.sv
// Shared types, constants and the octet-to-decimal helper for the flow hash.
// No dependencies.
`default_nettype none
package sfh_pkg;

  localparam int unsigned TextCells = 21;   // longest "a.b.c.d:port"
  localparam int unsigned LenW      = 5;
  localparam logic [7:0]  ProtoTcp  = 8'd6;
  localparam logic [7:0]  CharZero  = 8'h30;
  localparam logic [7:0]  CharDot   = 8'h2e;
  localparam logic [7:0]  CharColon = 8'h3a;
  localparam logic [31:0] HashPrimeLow = 32'd403;  // prime = 2^24 + 403

  typedef logic [7:0] char_t;

  typedef struct packed {
    logic clr;
    logic wr;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][3:0] d;   // d[0] is the ones digit
  } dec3_t;

  // Decimal digits of one octet; x/10 done as (x*205)>>11.
  function automatic dec3_t dec8(input logic [7:0] v);
    logic [18:0] p0;
    logic [7:0]  q0;
    logic [18:0] p1;
    logic [7:0]  q1;
    dec3_t       r;
    p0 = 19'(v) * 19'd205;
    q0 = p0[18:11];
    p1 = 19'(q0) * 19'd205;
    q1 = p1[18:11];
    r.d[0] = 4'(v - 8'(q0 * 8'd10));
    r.d[1] = 4'(q0 - 8'(q1 * 8'd10));
    r.d[2] = q1[3:0];
    r.cnt  = (v >= 8'd100) ? 2'd3 : ((v >= 8'd10) ? 2'd2 : 2'd1);
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/sfh_cell.sv
// One character cell of an endpoint text chain.
// Depends on sfh_pkg.
`default_nettype none
module sfh_cell (
  input  wire                  clk,
  input  sfh_pkg::cell_ctl_t   ctl,
  input  wire                  sel,
  input  sfh_pkg::char_t       wr_char,
  input  sfh_pkg::char_t       nbr,
  output sfh_pkg::char_t       q
);
  import sfh_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      q <= '0;
    end else if (ctl.wr && sel) begin
      q <= wr_char;
    end else if (ctl.shift) begin
      q <= nbr;             // move one place toward the head
    end
  end
endmodule
`default_nettype wire

// File: rtl/sfh_text.sv
// Endpoint text builder: writes "a.b.c.d:port" into a chain of cells and
// shifts it out head first. Depends on sfh_pkg and sfh_cell.
`default_nettype none
module sfh_text (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       start,
  input  wire                       shift,
  input  wire [31:0]                addr,
  input  wire [15:0]                port,
  output logic                      done,
  output logic [sfh_pkg::LenW-1:0]  len,
  output sfh_pkg::char_t            head
);
  import sfh_pkg::*;

  typedef enum logic [1:0] {T_IDLE, T_SPLIT, T_EMIT, T_DONE} tstate_t;

  tstate_t         state;
  logic [31:0]     addr_sh;
  logic [15:0]     pv;
  logic [4:0][3:0] pd;
  logic [2:0]      pcnt;
  logic [2:0]      step;
  logic [2:0]      tok;
  logic [2:0]      dig;

  logic [32:0]     pmul;
  logic [15:0]     pq;
  dec3_t           oc;
  logic [2:0]      ndig;
  logic [2:0]      didx;
  logic [3:0]      digit;
  char_t           wchar;
  logic            is_digit;
  logic            last_char;
  cell_ctl_t       ctl;
  char_t           cells [TextCells];

  // port / 10 as (p * 0xCCCD) >> 19
  assign pmul = 33'(pv) * 33'h0CCCD;
  assign pq   = 16'(pmul[32:19]);

  always_comb begin
    oc   = dec8(addr_sh[31:24]);
    ndig = (tok == 3'd4) ? pcnt : {1'b0, oc.cnt};
    didx = 3'(ndig - 3'd1 - dig);
    digit = (tok == 3'd4) ? pd[didx] : oc.d[didx[1:0]];
    is_digit  = (dig < ndig);
    wchar     = is_digit ? (CharZero + {4'd0, digit})
                         : ((tok == 3'd3) ? CharColon : CharDot);
    last_char = (tok == 3'd4) && (dig == 3'(ndig - 3'd1));
    ctl.clr   = start;
    ctl.wr    = (state == T_EMIT);
    ctl.shift = shift;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      len   <= '0;
    end else begin
      case (state)
        T_IDLE, T_DONE: begin
          if (start) begin
            state   <= T_SPLIT;
            addr_sh <= addr;
            pv      <= port;
            pcnt    <= 3'd1;
            step    <= '0;
            tok     <= '0;
            dig     <= '0;
            len     <= '0;
          end
        end
        T_SPLIT: begin
          pd[step] <= 4'(pv - 16'(pq * 16'd10));
          if (pv != 16'd0) pcnt <= 3'(step + 3'd1);
          pv   <= pq;
          step <= 3'(step + 3'd1);
          if (step == 3'd4) state <= T_EMIT;
        end
        T_EMIT: begin
          len <= LenW'(len + 1'b1);
          if (is_digit) begin
            dig <= 3'(dig + 3'd1);
            if (last_char) state <= T_DONE;
          end else begin
            dig     <= '0;
            tok     <= 3'(tok + 3'd1);
            addr_sh <= {addr_sh[23:0], 8'd0};
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  for (genvar i = 0; i < TextCells; i++) begin : g_cell
    sfh_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .sel     (len == LenW'(i)),
      .wr_char (wchar),
      .nbr     ((i == TextCells - 1) ? char_t'(0) : cells[(i + 1) % TextCells]),
      .q       (cells[i])
    );
  end

  assign head = cells[0];
  assign done = (state == T_DONE);
endmodule
`default_nettype wire

// File: rtl/symmetric_flow_hash_dispatch.sv
// Top level of the symmetric flow hash dispatcher.
// Depends on sfh_pkg, sfh_text, sfh_cell and the assertion macro header.
`default_nettype none
// One packet header is taken per beat on in_valid/in_ready and one result beat
// leaves on out_valid/out_ready. Non-TCP headers go straight to the result
// stage with all result fields zero. A TCP header builds both endpoint texts
// in parallel in two 21-cell character chains (a port digit split, then the
// characters written one at a time, 9 to 21 of them), then the chains shift
// out head first into the hash register, one character position per cycle
// until the longer text is used up, then a bit-serial restoring remainder
// reduces the hash by the queue count. No new header is taken until the
// current result is loaded into the output register. The next header is taken
// while a finished result still waits in the output register. queue_count is
// written on cfg_valid/cfg_ready (always ready); 0 acts as 1 and values above
// MAX_QUEUES saturate. Reset value of queue_count is 9.
module symmetric_flow_hash_dispatch #(
  parameter int unsigned MAX_QUEUES = 64
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  protocol,
  input  wire  [31:0] src_addr,
  input  wire  [31:0] dst_addr,
  input  wire  [15:0] src_port,
  input  wire  [15:0] dst_port,
  output logic        out_valid,
  input  wire         out_ready,
  output logic        dispatched,
  output logic [5:0]  queue_index,
  output logic [31:0] flow_hash,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [6:0]  cfg_data
);
  import sfh_pkg::*;
`include "symmetric_flow_hash_dispatch_defines.svh"

  typedef enum logic [2:0] {S_IDLE, S_BUILD, S_HASH, S_MOD, S_DONE} state_t;

  state_t            state;
  logic [6:0]        queue_count;
  logic [31:0]       h;
  logic [6:0]        rem;
  logic [4:0]        bitn;
  logic [LenW-1:0]   hcnt;
  logic              res_disp;

  logic              start;
  logic              done_a, done_b;
  logic [LenW-1:0]   len_a, len_b, hash_len;
  char_t             head_a, head_b;
  logic              shift;
  logic [6:0]        qc_eff;
  logic [31:0]       h_next;
  logic [7:0]        trial;
  logic [6:0]        rem_next;
  logic              out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign start     = in_valid && in_ready && (protocol == ProtoTcp);
  assign shift     = (state == S_HASH);
  assign hash_len  = (len_a > len_b) ? len_a : len_b;

  // Saturate the queue count, then treat zero as one.
  always_comb begin
    qc_eff = (32'(queue_count) > MAX_QUEUES) ? 7'(MAX_QUEUES) : queue_count;
    if (qc_eff == 7'd0) qc_eff = 7'd1;
  end

  // h * prime mod 2^32, prime = 2^24 + 403; empty cells read zero, so past the
  // shorter text the sum is just the longer text's character.
  assign h_next = ({h[7:0], 24'd0} + 32'(h * HashPrimeLow))
                  ^ {23'd0, 9'({1'b0, head_a} + {1'b0, head_b})};

  assign trial    = {rem, h[bitn]};
  assign rem_next = (trial >= {1'b0, qc_eff}) ? 7'(trial - {1'b0, qc_eff}) : trial[6:0];

  sfh_text u_text_src (
    .clk(clk), .rst(rst), .start(start), .shift(shift),
    .addr(src_addr), .port(src_port),
    .done(done_a), .len(len_a), .head(head_a)
  );

  sfh_text u_text_dst (
    .clk(clk), .rst(rst), .start(start), .shift(shift),
    .addr(dst_addr), .port(dst_port),
    .done(done_b), .len(len_b), .head(head_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      queue_count <= 7'd9;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) queue_count <= cfg_data;
      // a new result in S_DONE takes over the slot instead
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            h        <= '0;
            rem      <= '0;
            hcnt     <= '0;
            bitn     <= 5'd31;
            res_disp <= (protocol == ProtoTcp);
            state    <= (protocol == ProtoTcp) ? S_BUILD : S_DONE;
          end
        end
        S_BUILD: begin
          if (done_a && done_b) state <= S_HASH;
        end
        S_HASH: begin
          h    <= h_next;
          hcnt <= LenW'(hcnt + 1'b1);
          if (LenW'(hcnt + 1'b1) == hash_len) state <= S_MOD;
        end
        S_MOD: begin
          rem  <= rem_next;
          bitn <= 5'(bitn - 5'd1);
          if (bitn == 5'd0) state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            dispatched  <= res_disp;
            queue_index <= rem[5:0];
            flow_hash   <= h;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SFH_ASSERT_IMPL(a_nodisp_zero, out_valid && !dispatched, queue_index == 6'd0 && flow_hash == 32'd0)
  `SFH_ASSERT_IMPL(a_rem_bound, state == S_MOD, rem < qc_eff)
  `SFH_ASSERT_NEXT(a_hash_to_mod, state == S_HASH && LenW'(hcnt + 1'b1) == hash_len, state == S_MOD)
endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the symmetric flow hash dispatcher.
// Depends on sfh_pkg and the symmetric_flow_hash_dispatch RTL; drives random
// and corner packet headers, predicts dispatch results and compares each beat.
module tb_top;
  import sfh_pkg::*;

  localparam int unsigned MaxQueues  = 64;
  localparam int unsigned RandItems  = 1800;
  localparam longint      CycleLimit = 2000000;
  localparam int          ReportMax  = 10;
  // Idle and stall rates, as percent of cycles.
  localparam int unsigned IdlePct    = 37;

  typedef struct packed {
    logic [7:0]  proto;
    logic [31:0] saddr;
    logic [31:0] daddr;
    logic [15:0] sport;
    logic [15:0] dport;
  } header_t;

  typedef struct packed {
    logic        hit;
    logic [5:0]  qidx;
    logic [31:0] hash;
  } verdict_t;

  typedef struct {
    logic [7:0] ch [0:23];
    int         len;
  } endpoint_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  protocol;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic        out_valid;
  logic        out_ready;
  logic        dispatched;
  logic [5:0]  queue_index;
  logic [31:0] flow_hash;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [6:0]  cfg_data;

  symmetric_flow_hash_dispatch #(.MAX_QUEUES(MaxQueues)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .protocol(protocol), .src_addr(src_addr), .dst_addr(dst_addr),
    .src_port(src_port), .dst_port(dst_port),
    .out_valid(out_valid), .out_ready(out_ready),
    .dispatched(dispatched), .queue_index(queue_index), .flow_hash(flow_hash),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Testbench copy of the queue_count register.
  logic [6:0] queue_cnt_shadow;

  header_t  header_q[$];    // headers waiting for the driver
  verdict_t verdict_q[$];   // expected dispatch results, oldest first
  int       mismatches;
  bit       quiet_phase;    // no idling or stalls while set
  longint   cycle_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Render "a.b.c.d:port" as ASCII.
  function automatic endpoint_t render_endpoint(logic [31:0] addr, logic [15:0] port);
    endpoint_t ep;
    int        k;
    int        v;
    int        nd;
    int        dg[0:5];
    ep.len = 0;
    for (int i = 0; i < 24; i++) ep.ch[i] = 8'h00;
    for (k = 0; k < 5; k++) begin
      v = (k < 4) ? int'(addr[31 - 8 * k -: 8]) : int'(port);
      nd = 0;
      do begin
        dg[nd] = v % 10;
        v = v / 10;
        nd++;
      end while (v != 0);
      for (int j = nd - 1; j >= 0; j--) begin
        ep.ch[ep.len] = CharZero + 8'(dg[j]);
        ep.len++;
      end
      if (k < 3) begin
        ep.ch[ep.len] = CharDot;
        ep.len++;
      end else if (k == 3) begin
        ep.ch[ep.len] = CharColon;
        ep.len++;
      end
    end
    return ep;
  endfunction

  function automatic verdict_t predict_dispatch(header_t h, logic [6:0] qcnt);
    verdict_t  r;
    endpoint_t a;
    endpoint_t b;
    endpoint_t lng;
    endpoint_t sht;
    logic [31:0] acc;
    int unsigned qc;
    r = '0;
    if (h.proto != ProtoTcp) return r;
    a = render_endpoint(h.saddr, h.sport);
    b = render_endpoint(h.daddr, h.dport);
    // Longer text leads; the source leads on a tie.
    if (a.len < b.len) begin
      lng = b; sht = a;
    end else begin
      lng = a; sht = b;
    end
    acc = '0;
    for (int i = 0; i < lng.len; i++) begin
      acc = acc * 32'd16777619;
      if (i < sht.len) acc = acc ^ (32'(lng.ch[i]) + 32'(sht.ch[i]));
      else acc = acc ^ 32'(lng.ch[i]);
    end
    qc = qcnt;
    if (qc == 0) qc = 1;            // zero count acts as one queue
    if (qc > MaxQueues) qc = MaxQueues;  // saturate oversize counts
    r.hit  = 1'b1;
    r.qidx = 6'(acc % qc);
    r.hash = acc;
    return r;
  endfunction

  function automatic logic [31:0] rand_addr();
    // Mix of short and long octets to vary text length.
    case ($urandom_range(0, 3))
      0: return {8'($urandom_range(0, 9)), 8'($urandom_range(0, 9)),
                 8'($urandom_range(0, 9)), 8'($urandom_range(0, 9))};
      1: return {8'($urandom_range(100, 255)), 8'($urandom_range(100, 255)),
                 8'($urandom_range(100, 255)), 8'($urandom_range(100, 255))};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_port();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 9));
      1: return 16'($urandom_range(10000, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic header_t rand_header();
    header_t h;
    h.proto = ($urandom_range(0, 99) < 80) ? ProtoTcp : 8'($urandom);
    h.saddr = rand_addr();
    h.daddr = rand_addr();
    h.sport = rand_port();
    h.dport = rand_port();
    return h;
  endfunction

  // Driver: presents queued headers; idles at random between beats.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) verdict_q.push_back(predict_dispatch(header_q.pop_front(), queue_cnt_shadow));
      if (header_q.size() > 0 && (quiet_phase || $urandom_range(0, 99) >= IdlePct)) begin
        in_valid <= 1'b1;
        protocol <= header_q[0].proto;
        src_addr <= header_q[0].saddr;
        dst_addr <= header_q[0].daddr;
        src_port <= header_q[0].sport;
        dst_port <= header_q[0].dport;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Driver pops on acceptance, so head of header_q is always what is presented.
  // Monitor: compares each result beat against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet_phase || ($urandom_range(0, 99) >= IdlePct);
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportMax)
            $display("unexpected result beat: hit=%0d q=%0d hash=%h",
                     dispatched, queue_index, flow_hash);
        end else begin
          verdict_t e;
          e = verdict_q.pop_front();
          if (dispatched !== e.hit || queue_index !== e.qidx || flow_hash !== e.hash) begin
            mismatches++;
            if (mismatches <= ReportMax)
              $display("mismatch: exp hit=%0d q=%0d hash=%h got hit=%0d q=%0d hash=%h",
                       e.hit, e.qidx, e.hash, dispatched, queue_index, flow_hash);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_queue_count(logic [6:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    queue_cnt_shadow = v;
    cfg_valid <= 1'b0;
  endtask

  // Wait until every queued header is out and its result checked.
  task automatic drain();
    while (header_q.size() > 0 || verdict_q.size() > 0 || in_valid) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic run_phase(logic [6:0] qcnt, int n);
    write_queue_count(qcnt);
    for (int i = 0; i < n; i++) header_q.push_back(rand_header());
    drain();
  endtask

  initial begin
    mismatches = 0;
    cycle_cnt = 0;
    quiet_phase = 1'b0;
    queue_cnt_shadow = 7'd9;
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    protocol = '0; src_addr = '0; dst_addr = '0; src_port = '0; dst_port = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset queue count, extremes, swapped endpoints, non-TCP.
    header_q.push_back('{ProtoTcp, 32'h0, 32'h0, 16'h0, 16'h0});
    header_q.push_back('{ProtoTcp, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF});
    header_q.push_back('{ProtoTcp, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0});
    header_q.push_back('{ProtoTcp, 32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF});
    header_q.push_back('{ProtoTcp, 32'h0A00_0001, 32'hC0A8_0102, 16'd80, 16'd51234});
    header_q.push_back('{ProtoTcp, 32'hC0A8_0102, 32'h0A00_0001, 16'd51234, 16'd80});
    header_q.push_back('{ProtoTcp, 32'h0102_0304, 32'h0403_0201, 16'd1, 16'd2});
    header_q.push_back('{ProtoTcp, 32'h6464_6464, 32'h0909_0909, 16'd9999, 16'd10});
    header_q.push_back('{8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF});
    header_q.push_back('{8'd17, 32'h0A00_0001, 32'h0A00_0002, 16'd53, 16'd53});
    header_q.push_back('{8'd255, 32'h0, 32'h0, 16'h0, 16'h0});
    header_q.push_back('{8'd7, 32'h1, 32'h2, 16'd3, 16'd4});
    drain();

    // Queue count sweep: zero, one, max, oversize, extremes of the field.
    run_phase(7'd0, 10);
    run_phase(7'd1, 10);
    run_phase(7'd64, 12);
    run_phase(7'd65, 8);
    run_phase(7'd127, 8);
    run_phase(7'h2A, 8);

    // Random phases with random counts; one runs without idling.
    for (int p = 0; p < 9; p++) begin
      quiet_phase = (p == 4);
      run_phase(7'($urandom_range(1, 64)), RandItems / 9);
    end
    quiet_phase = 1'b0;
    run_phase(7'($urandom), 20);

    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// File: symmetric_flow_hash_dispatch.f
+incdir+rtl
rtl/sfh_pkg.sv
rtl/sfh_cell.sv
rtl/sfh_text.sv
rtl/symmetric_flow_hash_dispatch.sv
tb/tb_top.sv
